### rtl/core/mhpd_pkg.sv
// Shared types, codes and constants for the sync-word packet deframer.
package mhpd_pkg;

    localparam logic [7:0]  SYNC_FIRST     = 8'h5A;
    localparam logic [7:0]  SYNC_SECOND    = 8'hA5;
    localparam logic [15:0] MIN_LENGTH     = 16'd2;
    localparam logic [15:0] MAX_LENGTH_RST = 16'd1024;

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_LENHI = 3'd2;
    localparam logic [2:0] PH_LENLO = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  length_high;
        logic [15:0] payload_length;
        logic [15:0] bytes_received;
        logic [15:0] framing_errors;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] packet_length;
        logic [15:0] error_count;
    } result_t;

endpackage

### rtl/core/mhpd_parser.sv
// Next-state and result logic for one received byte of the deframer.
module mhpd_parser
    import mhpd_pkg::*;
(
    input  parse_state_t state,
    input  logic [15:0]  max_length,
    input  logic [7:0]   rx_byte,
    output parse_state_t state_next,
    output result_t      result
);

    logic [15:0] len;
    logic [15:0] count_inc;
    logic        err;

    assign len       = {state.length_high, rx_byte};
    assign count_inc = state.bytes_received + 16'd1;

    always_comb
    begin
        state_next           = state;
        result.kind          = KIND_HEADER;
        result.payload_byte  = 8'd0;
        result.last          = 1'b0;
        result.packet_length = 16'd0;
        err                  = 1'b0;

        case (state.phase)
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                begin
                    state_next.phase = PH_LENHI;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            PH_LENHI:
            begin
                state_next.length_high = rx_byte;
                state_next.phase       = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (len < MIN_LENGTH || len > max_length)
                begin
                    err = 1'b1;
                end
                else
                begin
                    state_next.payload_length = len;
                    state_next.bytes_received = 16'd0;
                    state_next.phase          = PH_DATA;
                    result.packet_length      = len;
                end
            end
            PH_DATA:
            begin
                result.kind               = KIND_PAYLOAD;
                result.payload_byte       = rx_byte;
                result.packet_length      = state.payload_length;
                state_next.bytes_received = count_inc;
                if (count_inc >= state.payload_length)
                begin
                    result.last               = 1'b1;
                    state_next.bytes_received = 16'd0;
                    state_next.phase          = PH_SYNC1;
                end
            end
            default:
            begin
                if (rx_byte == SYNC_FIRST)
                begin
                    state_next.phase = PH_SYNC2;
                end
                else
                begin
                    err = 1'b1;
                end
            end
        endcase

        if (err)
        begin
            state_next.framing_errors = state.framing_errors + 16'd1;
            state_next.phase          = PH_SYNC1;
            result.kind               = KIND_ERROR;
        end

        result.error_count = state_next.framing_errors;
    end

endmodule

### rtl/core/magic_header_packet_deframer_unit.sv
// Top level of the sync-word, length-prefixed packet deframer.
// Each received byte yields one result item: header byte consumed, payload byte
// (with last marked on the final one and the packet length alongside) or framing
// error (with the wrapping error count). An item is taken every cycle while
// in_stall is low; its result goes to the result register, or to the skid
// register while a result waits. The parse state updates in a single pass at
// the input handshake. This two-entry output stage stalls input only when both
// entries are full. The user must write max_length (reset 1024) through cfg_wr_en
// and cfg_wr_data only while no item is in flight; the block does not enforce it.
module magic_header_packet_deframer_unit
    import mhpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        last,
    output logic [15:0] packet_length,
    output logic [15:0] error_count
);

    logic [15:0]  max_length_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_next;
    result_t      out_reg;
    result_t      skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         in_accept;
    logic         out_take;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    mhpd_parser u_parser
    (
        .state      (state_reg),
        .max_length (max_length_reg),
        .rx_byte    (rx_byte),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            max_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= result_next;
            end
            else
            begin
                skid_reg <= result_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign last          = out_reg.last;
    assign packet_length = out_reg.packet_length;
    assign error_count   = out_reg.error_count;

endmodule

### rtl/core/mhpd_checker.sv
// Port-level checks for the deframer, bound to the top level.
module mhpd_checker
    import mhpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  payload_byte,
    input logic        last,
    input logic [15:0] packet_length,
    input logic [15:0] error_count
);

    a_non_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && !last)
        else $error("non-payload item carries data or last");

    a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> packet_length == 16'd0)
        else $error("framing error item carries a packet length");

    a_payload_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PAYLOAD |-> packet_length >= MIN_LENGTH)
        else $error("payload item with a length below the minimum");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(error_count)
            && $stable(payload_byte) && $stable(last) && $stable(packet_length))
        else $error("stalled result item changed");

endmodule

bind magic_header_packet_deframer_unit mhpd_checker u_mhpd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .last          (last),
    .packet_length (packet_length),
    .error_count   (error_count)
);
